>>> sv/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page frame allocator package
// Widths, status and command codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int ADDR_W    = 48;
  localparam int CNT_W     = 17;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int REG_IDX_W = 1;

  localparam int DEF_MAX_FRAMES = 65536;
  localparam int DEF_PAGE_BITS  = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_BASE  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 1'b1;

  // Outcome of looking for a clear bit in one bitmap word.
  typedef struct packed {
    logic              hit;
    logic [BIT_W-1:0]  bit_idx;
    logic [WORD_W-1:0] word_set;
  } pick_t;

endpackage

>>> sv/bpfa_if.sv
// ----------------------------------------------------------------------------
// Bitmap page frame allocator channels
// Command channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpfa_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [bpfa_pkg::ADDR_W-1:0] page_address;

  modport source (output valid, output command, output page_address, input ready);
  modport sink   (input valid, input command, input page_address, output ready);
endinterface

interface bpfa_res_if;
  logic                          valid;
  logic                          ready;
  logic [bpfa_pkg::STATUS_W-1:0] status;
  logic [bpfa_pkg::ADDR_W-1:0]   granted_address;
  logic [bpfa_pkg::CNT_W-1:0]    free_frames;

  modport source (output valid, output status, output granted_address, output free_frames,
                  input ready);
  modport sink   (input valid, input status, input granted_address, input free_frames,
                  output ready);
endinterface

>>> sv/bpfa_word_pick.sv
// ----------------------------------------------------------------------------
// Bitmap word picker
// Finds the lowest clear bit of a word within a window mask and sets it.
// ----------------------------------------------------------------------------
module bpfa_word_pick (
  input  logic [bpfa_pkg::WORD_W-1:0] word,
  input  logic [bpfa_pkg::WORD_W-1:0] mask,
  output bpfa_pkg::pick_t             pick
);

  logic [bpfa_pkg::WORD_W-1:0] cand;
  logic [bpfa_pkg::BIT_W-1:0]  pos;

  assign cand = ~word & mask;

  // Scan from the top so that the lowest candidate wins.
  always_comb begin
    pos = '0;
    for (int i = bpfa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = bpfa_pkg::BIT_W'(i);
      end
    end
  end

  assign pick.hit      = |cand;
  assign pick.bit_idx  = pos;
  assign pick.word_set = word | (bpfa_pkg::WORD_W'(1) << pos);

endmodule

>>> sv/bitmap_page_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap page frame allocator core
// Next-fit page frame allocator with one in-use bit per frame held in a RAM.
// ----------------------------------------------------------------------------
// The block handles one command at a time. After reset it runs a clearing
// pass that marks every frame as used, one 64-bit bitmap word per cycle;
// no command is taken during that pass, although register writes are.
// Frames are then made available by freeing them one at a time. An allocate
// reads the bitmap RAM one word per cycle starting at the word that holds
// the search cursor, until a clear bit turns up; with a full map it reads
// every active word once, plus the cursor word a second time. A free runs
// through address subtract, range check, read, modify and write, and the
// hand-over to the result register; a rejected free skips the read and the
// modify and write. The result register decouples the output: a new command
// is accepted as soon as the previous one has been handed to the result
// register.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core #(
  parameter int MAX_FRAMES = bpfa_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = bpfa_pkg::DEF_PAGE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bpfa_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [bpfa_pkg::ADDR_W-1:0]    wr_data,
  bpfa_cmd_if.sink                       cmd,
  bpfa_res_if.source                     res
);

  localparam int ADDR_W    = bpfa_pkg::ADDR_W;
  localparam int CNT_W     = bpfa_pkg::CNT_W;
  localparam int WORD_W    = bpfa_pkg::WORD_W;
  localparam int BIT_W     = bpfa_pkg::BIT_W;
  localparam int STATUS_W  = bpfa_pkg::STATUS_W;
  localparam int MAP_WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'(1) << PAGE_BITS) - 64'(1));

  // Sequencer state codes.
  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_AWR  = 4'd3;
  localparam logic [3:0] S_FSUB = 4'd4;
  localparam logic [3:0] S_FCHK = 4'd5;
  localparam logic [3:0] S_FRD  = 4'd6;
  localparam logic [3:0] S_FUPD = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  function automatic logic [WORD_W-1:0] ones_below(input logic [BIT_W-1:0] b);
    return (WORD_W'(1) << b) - WORD_W'(1);
  endfunction

  logic [3:0] state;

  // Configuration registers.
  logic [ADDR_W-1:0] base_address;
  logic [CNT_W-1:0]  frame_count;

  // Allocator state outside the bitmap.
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] free_counter;

  // Bitmap RAM and its ports.
  logic [WORD_W-1:0]  mem [MAP_WORDS];
  logic [WORD_W-1:0]  rdata;
  logic               mem_we;
  logic [WADDR_W-1:0] mem_waddr;
  logic [WADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WADDR_W-1:0] init_addr;

  // Scan control: issue side and check side of the read pipeline.
  logic [WADDR_W-1:0] iw;
  logic [WADDR_W-1:0] sw;
  logic [WADDR_W-1:0] lw;
  logic [BIT_W-1:0]   start_bit;
  logic [BIT_W-1:0]   last_bit;
  logic               phase;
  logic               issue_on;
  logic               chk_valid;
  logic [WADDR_W-1:0] chk_addr;
  logic [WORD_W-1:0]  chk_mask;
  logic               chk_last;
  logic [WORD_W-1:0]  issue_mask;
  bpfa_pkg::pick_t    pick;

  // Per-command working registers.
  logic [CNT_W-1:0]    idx;
  logic [WADDR_W-1:0]  idx_word;
  logic [WORD_W-1:0]   word_upd;
  logic [ADDR_W-1:0]   pa;
  logic [ADDR_W:0]     diff;
  logic [ADDR_W-1:0]   frame_off;
  logic                reject;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_grant;

  // Result register.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_grant;
  logic [CNT_W-1:0]    out_free;

  logic [ADDR_W-1:0] base_page;
  logic [CNT_W-1:0]  n_active;
  logic [CNT_W-1:0]  n_last;
  logic [CNT_W-1:0]  start;

  // A count above the bitmap size is clamped to the bitmap size.
  always_comb begin
    if (32'(frame_count) > MAX_FRAMES) begin
      n_active = CNT_W'(MAX_FRAMES);
    end else begin
      n_active = frame_count;
    end
  end

  assign base_page = base_address & ~PAGE_MASK;
  assign n_last    = n_active - CNT_W'(1);
  // A cursor that has run off the end of the active range restarts at frame 0.
  assign start     = (cursor < n_active) ? cursor : '0;
  assign idx_word  = WADDR_W'(idx >> BIT_W);
  assign frame_off = diff[ADDR_W-1:0] >> PAGE_BITS;
  assign reject    = diff[ADDR_W] || ((pa & PAGE_MASK) != '0) ||
                     (frame_off >= ADDR_W'(n_active));

  // The search runs in two passes. The first covers the cursor up to the last
  // active frame; the second wraps round from frame 0 up to just below the
  // cursor. The window mask limits each word to the frames of its pass.
  always_comb begin
    issue_mask = '1;
    if (!phase) begin
      if (iw == sw) begin
        issue_mask = issue_mask & ~ones_below(start_bit);
      end
      if (iw == lw) begin
        issue_mask = issue_mask & ((ones_below(last_bit) << 1) | WORD_W'(1));
      end
    end else if (iw == sw) begin
      issue_mask = ones_below(start_bit);
    end
  end

  bpfa_word_pick u_pick (
    .word (rdata),
    .mask (chk_mask),
    .pick (pick)
  );

  // RAM port steering.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_word;
    mem_wdata = word_upd;
    mem_raddr = iw;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr;
        mem_wdata = '1;
      end
      S_AWR: begin
        mem_we = 1'b1;
      end
      S_FRD: begin
        mem_raddr = idx_word;
      end
      S_FUPD: begin
        mem_we    = rdata[idx[BIT_W-1:0]];
        mem_wdata = rdata & ~(WORD_W'(1) << idx[BIT_W-1:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  assign cmd.ready           = (state == S_IDLE);
  assign res.valid           = out_valid;
  assign res.status          = out_status;
  assign res.granted_address = out_grant;
  assign res.free_frames     = out_free;

  // Payload registers of the working set need no reset.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          sw        <= WADDR_W'(start >> BIT_W);
          iw        <= WADDR_W'(start >> BIT_W);
          lw        <= WADDR_W'(n_last >> BIT_W);
          start_bit <= start[BIT_W-1:0];
          last_bit  <= n_last[BIT_W-1:0];
          pa        <= cmd.page_address;
          res_grant <= '0;
          if (n_active == '0) begin
            res_status <= bpfa_pkg::ST_NO_FREE;
          end
        end
      end
      S_SCAN: begin
        if (issue_on) begin
          chk_addr <= iw;
          chk_mask <= issue_mask;
          chk_last <= phase && (iw == sw);
          if (!phase && (iw == lw)) begin
            iw <= '0;
          end else if (!(phase && (iw == sw))) begin
            iw <= iw + WADDR_W'(1);
          end
        end
        if (chk_valid) begin
          if (pick.hit) begin
            idx      <= CNT_W'({chk_addr, pick.bit_idx});
            word_upd <= pick.word_set;
          end else if (chk_last) begin
            res_status <= bpfa_pkg::ST_NO_FREE;
          end
        end
      end
      S_AWR: begin
        res_grant  <= base_page + (ADDR_W'(idx) << PAGE_BITS);
        res_status <= bpfa_pkg::ST_DONE;
      end
      S_FSUB: begin
        diff <= {1'b0, pa} - {1'b0, base_page};
      end
      S_FCHK: begin
        idx <= CNT_W'(frame_off);
        if (reject) begin
          res_status <= bpfa_pkg::ST_REJECTED;
        end
      end
      S_FUPD: begin
        if (rdata[idx[BIT_W-1:0]]) begin
          res_status <= bpfa_pkg::ST_DONE;
        end else begin
          res_status <= bpfa_pkg::ST_ALREADY_FREE;
        end
      end
      S_DONE: begin
        if (!out_valid || res.ready) begin
          out_status <= res_status;
          out_grant  <= res_grant;
          out_free   <= free_counter;
        end
      end
      default: begin
        res_grant <= res_grant;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_addr    <= '0;
      base_address <= '0;
      frame_count  <= '0;
      cursor       <= '0;
      free_counter <= '0;
      phase        <= 1'b0;
      issue_on     <= 1'b0;
      chk_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          bpfa_pkg::REG_BASE:  base_address <= wr_data;
          bpfa_pkg::REG_COUNT: frame_count  <= wr_data[CNT_W-1:0];
          default:             frame_count  <= frame_count;
        endcase
      end

      if (res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          init_addr <= init_addr + WADDR_W'(1);
          if (init_addr == WADDR_W'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.command == bpfa_pkg::CMD_FREE) begin
              state <= S_FSUB;
            end else if (n_active == '0) begin
              state <= S_DONE;
            end else begin
              phase     <= 1'b0;
              issue_on  <= 1'b1;
              chk_valid <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= issue_on;
          if (issue_on) begin
            if (!phase && (iw == lw)) begin
              phase <= 1'b1;
            end else if (phase && (iw == sw)) begin
              issue_on <= 1'b0;
            end
          end
          // A read still in flight when the search ends is simply dropped.
          if (chk_valid && (pick.hit || chk_last)) begin
            issue_on  <= 1'b0;
            chk_valid <= 1'b0;
            state     <= pick.hit ? S_AWR : S_DONE;
          end
        end
        S_AWR: begin
          cursor <= idx + CNT_W'(1);
          if (free_counter != '0) begin
            free_counter <= free_counter - CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_FSUB: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          state <= reject ? S_DONE : S_FRD;
        end
        S_FRD: begin
          state <= S_FUPD;
        end
        S_FUPD: begin
          if (rdata[idx[BIT_W-1:0]] && (free_counter != bpfa_pkg::CNT_MAX)) begin
            free_counter <= free_counter + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
